/* design/ess_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine start/stop sequencer package
// Shared types, command and mode codes, and the reset values of the
// configuration registers.
// ----------------------------------------------------------------------------
package ess_pkg;

  // Command codes as carried on the command fields and held in the latch.
  localparam logic [1:0] CMD_STOP  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_NONE  = 2'd2;

  // Control mode codes.
  localparam logic [1:0] MODE_REMOTE = 2'd0;
  localparam logic [1:0] MODE_UPPER  = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_RUN_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_POWER_WAIT    = 2'd1;
  localparam logic [1:0] REG_CRANK_TICKS   = 2'd2;
  localparam logic [1:0] REG_STOP_WAIT     = 2'd3;

  // Configuration reset values.
  localparam logic [11:0] RUN_THRESHOLD_RST = 12'd500;
  localparam logic [15:0] POWER_WAIT_RST    = 16'd1100;
  localparam logic [15:0] CRANK_TICKS_RST   = 16'd250;
  localparam logic [15:0] STOP_WAIT_RST     = 16'd200;

  // Stream word widths.
  localparam int unsigned TICK_W     = 19;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned RES_W      = 5;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    START_POWER_ON  = 3'd0,
    START_POWER_WAIT = 3'd1,
    START_CRANK_ON  = 3'd2,
    START_CRANK_WAIT = 3'd3,
    START_CRANK_OFF = 3'd4
  } start_phase_e;

  typedef enum logic [1:0] {
    STOP_FIRST_OFF = 2'd0,
    STOP_WAIT      = 2'd1,
    STOP_FINAL_OFF = 2'd2
  } stop_phase_e;

  // One tick word, first field in the highest bits.
  typedef struct packed {
    logic [11:0] speed;
    logic [1:0]  upper_cmd;
    logic [1:0]  remote_cmd;
    logic [1:0]  mode;
    logic        halt;
  } tick_t;

  // One result word, first field in the highest bits.
  typedef struct packed {
    logic running;
    logic speed_clear;
    logic throttle_zero;
    logic crank_relay;
    logic power_relay;
  } result_t;

  typedef struct packed {
    logic [11:0] run_threshold;
    logic [15:0] power_wait_ticks;
    logic [15:0] crank_ticks;
    logic [15:0] stop_wait_ticks;
  } cfg_t;

endpackage

/* design/engine_start_stop_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine start/stop sequencer
// Turns 10 ms tick words into relay levels, throttle and speed-clear pulses
// and the running flag.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the s_axis channel is one control tick. It is captured in an
//   input register, evaluated against the sequencer state in one pass of
//   logic, and the result word is held in an output register on m_axis.
//   The result word is registered in the output register as its tick advances.
//   Throughput is one word per cycle while m_axis accepts: the sequencer
//   state update is the only loop and it closes through one pass of logic.
//   When the receiver stalls, the output register holds its word, the input
//   register holds one more, and s_axis_tready drops until m_axis drains.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i by the user only while no tick is in flight (the block does
//   not enforce it); writes take effect at once. Reset returns the
//   configuration to its defaults, clears the command latch to no command,
//   opens both relays and empties both registers.
// ----------------------------------------------------------------------------
module engine_start_stop_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick words: halt[0], mode[2:1], remote_cmd[4:3], upper_cmd[6:5],
  // speed[18:7], zero fill [23:19]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // Result words: power_relay[0], crank_relay[1], throttle_zero[2],
  // speed_clear[3], running[4], zero fill [7:5]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import ess_pkg::*;

  tick_t   tick_q;
  logic    in_vld_q;
  result_t res;
  result_t res_q;
  logic    out_vld_q;
  logic    advance;
  cfg_t    cfg_q;

  // A tick advances when the output register is free or being emptied.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q <= s_axis_tdata[TICK_W-1:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_threshold    <= RUN_THRESHOLD_RST;
      cfg_q.power_wait_ticks <= POWER_WAIT_RST;
      cfg_q.crank_ticks      <= CRANK_TICKS_RST;
      cfg_q.stop_wait_ticks  <= STOP_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RUN_THRESHOLD: cfg_q.run_threshold    <= cfg_wdata_i[11:0];
        REG_POWER_WAIT:    cfg_q.power_wait_ticks <= cfg_wdata_i;
        REG_CRANK_TICKS:   cfg_q.crank_ticks      <= cfg_wdata_i;
        REG_STOP_WAIT:     cfg_q.stop_wait_ticks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ess_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tick_i (tick_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, res_q};

endmodule

/* design/ess_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine start/stop sequencer core
// Holds the sequencer state and computes one tick's update and result in a
// single pass of combinational logic; state commits when step_i is high.
// ----------------------------------------------------------------------------
module ess_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  ess_pkg::tick_t  tick_i,
  input  ess_pkg::cfg_t   cfg_i,
  output ess_pkg::result_t res_o
);
  import ess_pkg::*;

  logic [1:0]   sel_q, sel_d;
  logic [1:0]   latch_q, latch_d;
  start_phase_e start_ph_q, start_ph_d;
  stop_phase_e  stop_ph_q, stop_ph_d;
  logic [15:0]  start_cnt_q, start_cnt_d;
  logic [15:0]  stop_cnt_q, stop_cnt_d;
  logic         run_q, run_d;
  logic         power_q, power_d;
  logic         crank_q, crank_d;
  logic         thr_zero;
  logic         spd_clear;
  logic [15:0]  start_cnt_inc;
  logic [15:0]  stop_cnt_inc;

  assign start_cnt_inc = start_cnt_q + 16'd1;
  assign stop_cnt_inc  = stop_cnt_q + 16'd1;

  // Next-state logic for one tick.
  always_comb begin
    sel_d       = sel_q;
    latch_d     = latch_q;
    start_ph_d  = start_ph_q;
    stop_ph_d   = stop_ph_q;
    start_cnt_d = start_cnt_q;
    stop_cnt_d  = stop_cnt_q;
    power_d     = power_q;
    crank_d     = crank_q;
    spd_clear   = 1'b0;

    // Command selection; an unknown mode keeps the previous command.
    if (tick_i.halt) begin
      sel_d = CMD_NONE;
    end else begin
      case (tick_i.mode)
        MODE_REMOTE: sel_d = tick_i.remote_cmd;
        MODE_UPPER:  sel_d = tick_i.upper_cmd;
        MODE_MANUAL: sel_d = CMD_NONE;
        default:     sel_d = sel_q;
      endcase
    end

    // Stop always latches; start only while the engine is not running.
    if (sel_d == CMD_STOP) begin
      latch_d = CMD_STOP;
    end else if (sel_d == CMD_START && !run_q) begin
      latch_d = CMD_START;
    end

    thr_zero = (latch_d == CMD_STOP) || (latch_d == CMD_START);

    // Start sequence; a latched stop drops both relays at once.
    if (latch_d == CMD_STOP) begin
      crank_d     = 1'b0;
      power_d     = 1'b0;
      start_ph_d  = START_POWER_ON;
      start_cnt_d = '0;
    end else if (latch_d == CMD_START) begin
      case (start_ph_q)
        START_POWER_ON: begin
          crank_d    = 1'b0;
          power_d    = 1'b1;
          start_ph_d = START_POWER_WAIT;
        end
        START_POWER_WAIT: begin
          start_cnt_d = start_cnt_inc;
          if (start_cnt_inc > cfg_i.power_wait_ticks) begin
            start_cnt_d = '0;
            start_ph_d  = START_CRANK_ON;
          end
        end
        START_CRANK_ON: begin
          power_d    = 1'b1;
          crank_d    = 1'b1;
          start_ph_d = START_CRANK_WAIT;
        end
        START_CRANK_WAIT: begin
          start_cnt_d = start_cnt_inc;
          if (start_cnt_inc > cfg_i.crank_ticks) begin
            start_cnt_d = '0;
            start_ph_d  = START_CRANK_OFF;
          end
        end
        START_CRANK_OFF: begin
          crank_d     = 1'b0;
          power_d     = 1'b1;
          latch_d     = CMD_NONE;
          start_ph_d  = START_POWER_ON;
          start_cnt_d = '0;
        end
        default: ;
      endcase
    end

    // Stop sequence; a latched start sends it back to its first step.
    if (latch_d == CMD_START) begin
      stop_ph_d  = STOP_FIRST_OFF;
      stop_cnt_d = '0;
    end else if (latch_d == CMD_STOP) begin
      case (stop_ph_q)
        STOP_FIRST_OFF: begin
          crank_d   = 1'b0;
          power_d   = 1'b0;
          spd_clear = 1'b1;
          stop_ph_d = STOP_WAIT;
        end
        STOP_WAIT: begin
          stop_cnt_d = stop_cnt_inc;
          if (stop_cnt_inc > cfg_i.stop_wait_ticks) begin
            stop_cnt_d = '0;
            stop_ph_d  = STOP_FINAL_OFF;
          end
        end
        STOP_FINAL_OFF: begin
          crank_d    = 1'b0;
          power_d    = 1'b0;
          latch_d    = CMD_NONE;
          spd_clear  = 1'b1;
          stop_ph_d  = STOP_FIRST_OFF;
          stop_cnt_d = '0;
        end
        default: ;
      endcase
    end

    run_d = (tick_i.speed >= cfg_i.run_threshold);
  end

  // Result word, running flag in the highest bit down to the power relay.
  assign res_o = {run_d, spd_clear, thr_zero, crank_d, power_d};

  // State registers, advanced once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= CMD_NONE;
      latch_q     <= CMD_NONE;
      start_ph_q  <= START_POWER_ON;
      stop_ph_q   <= STOP_FIRST_OFF;
      start_cnt_q <= '0;
      stop_cnt_q  <= '0;
      run_q       <= 1'b0;
      power_q     <= 1'b0;
      crank_q     <= 1'b0;
    end else if (step_i) begin
      sel_q       <= sel_d;
      latch_q     <= latch_d;
      start_ph_q  <= start_ph_d;
      stop_ph_q   <= stop_ph_d;
      start_cnt_q <= start_cnt_d;
      stop_cnt_q  <= stop_cnt_d;
      run_q       <= run_d;
      power_q     <= power_d;
      crank_q     <= crank_d;
    end
  end

  // The crank relay is never closed without engine power.
  a_crank_needs_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crank_q |-> power_q)
    else $error("crank relay closed while power relay is open");

  // A start sequence in progress always has a start latched.
  a_start_phase_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_ph_q != START_POWER_ON) |-> (latch_q == CMD_START))
    else $error("start sequence active without a latched start");

  // A stop sequence in progress always has a stop latched.
  a_stop_phase_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stop_ph_q != STOP_FIRST_OFF) |-> (latch_q == CMD_STOP))
    else $error("stop sequence active without a latched stop");

endmodule
